// File: design/rsr_pkg.sv
// ============================================================================
// rsr_pkg
// Types and fixed constants for the radial sine ripple pixel generator.
// ============================================================================
package rsr_pkg;

  // register indexes on the write port
  localparam logic [2:0] REG_IMG_SIDE    = 3'd0;
  localparam logic [2:0] REG_OFFSET_X    = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd2;
  localparam logic [2:0] REG_SCALE_RED   = 3'd3;
  localparam logic [2:0] REG_SCALE_GREEN = 3'd4;
  localparam logic [2:0] REG_SCALE_BLUE  = 3'd5;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // square root: radicand is (dx^2 + dy^2) << 8, padded to an even width
  localparam int SQ_IN_W    = 38;
  localparam int SQ_STEPS   = SQ_IN_W / 2;
  localparam int SQ_PER_STG = 4;
  localparam int SQ_STG     = (SQ_STEPS + SQ_PER_STG - 1) / SQ_PER_STG;
  localparam int SQ_ROOT_W  = SQ_STEPS;
  localparam int SQ_REM_W   = SQ_ROOT_W + 4;

  localparam int DIST_W = 17;
  localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

  // round(2^32 / (2*pi)) split in two 15-bit halves
  localparam longint INV_TWO_PI = 64'd683565276;
  localparam logic [14:0] INV_LO = 15'(INV_TWO_PI & 64'h7FFF);
  localparam logic [14:0] INV_HI = 15'(INV_TWO_PI >> 15);

  // quarter-wave polynomial
  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [15:0] SIN_B = 16'd21167;
  localparam logic [11:0] SIN_C = 12'd2463;

  localparam logic [16:0] HALF_SCALE = 17'd32768;
  localparam logic [16:0] FULL_TURN  = 17'd65536;
  localparam logic [7:0]  LEVELS     = 8'd255;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

endpackage

// File: design/radial_sine_ripple_pixel.sv
// ============================================================================
// radial_sine_ripple_pixel
// Ripple test-pattern pixel: RGB from the sine of scaled radial distance.
// ============================================================================
//
//  channel | signals                        | role
//  --------+--------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_item    | pixel coordinate, one item
//  out     | out_valid, out_ready, out_item | RGB result, one item
//  config  | wr_en, wr_index, wr_data       | register write, no read-back
//
//  One item per clock sustained while the output is not stalled. Depth: offset,
//  square and radicand stages, five-stage square root (up to 4 result bits a
//  stage), phase and turns multiplies, quadrant fold, sine polynomial stages.
//  Each stage has its own valid bit and advances when it is empty or the next
//  stage advances, so a stalled output still lets bubbles fill behind it.
//  rst (synchronous) empties the pipe and loads the register defaults.
//
module radial_sine_ripple_pixel #(
  parameter int MAX_SIDE        = 4096,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsr_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rsr_pkg::out_item_t              out_item,
  input  logic                            wr_en,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [rsr_pkg::CFG_DATA_W-1:0]  wr_data
);

  localparam int NSTG   = 11 + rsr_pkg::SQ_STG;   // total register stages
  localparam int ST_SQ0 = 3;                      // first sqrt stage
  localparam int ST_P   = ST_SQ0 + rsr_pkg::SQ_STG;
  localparam int FULL_W = SCALE_FRAC_BITS + 36;
  localparam int ANG_LSB = SCALE_FRAC_BITS + 20;
  localparam logic [17:0] SIDE_CAP = 18'(MAX_SIDE);

  // ---------------- configuration registers ----------------
  logic        [12:0] img_side;
  logic signed [13:0] offset_x;
  logic signed [13:0] offset_y;
  logic signed [15:0] scale [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      img_side <= 13'd256;
      offset_x <= '0;
      offset_y <= '0;
      scale[0] <= 16'sd4096;
      scale[1] <= 16'sd4096;
      scale[2] <= 16'sd4096;
    end else if (wr_en) begin
      case (wr_index)
        rsr_pkg::REG_IMG_SIDE:    img_side <= wr_data[12:0];
        rsr_pkg::REG_OFFSET_X:    offset_x <= wr_data[13:0];
        rsr_pkg::REG_OFFSET_Y:    offset_y <= wr_data[13:0];
        rsr_pkg::REG_SCALE_RED:   scale[0] <= wr_data;
        rsr_pkg::REG_SCALE_GREEN: scale[1] <= wr_data;
        rsr_pkg::REG_SCALE_BLUE:  scale[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------- stage 0: offsets from the center ----------------
  logic        [12:0] side_c;
  logic signed [14:0] cx, cy;
  logic signed [14:0] dx, dy;

  always_comb begin
    side_c = ({5'd0, img_side} > SIDE_CAP) ? SIDE_CAP[12:0] : img_side;
    cx = $signed({3'b000, side_c[12:1]}) + 15'(offset_x);
    cy = $signed({3'b000, side_c[12:1]}) + 15'(offset_y);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx <= $signed({3'b000, in_item.pixel_x}) - cx;
      dy <= $signed({3'b000, in_item.pixel_y}) - cy;
    end
  end

  // ---------------- stage 1: squares ----------------
  logic signed [29:0] sqx_full, sqy_full;
  logic [27:0] sqx, sqy;

  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sqx <= sqx_full[27:0];
      sqy <= sqy_full[27:0];
    end
  end

  // ---------------- stage 2: radicand ----------------
  logic [28:0] sum_sq;
  logic [rsr_pkg::SQ_IN_W-1:0]   rad  [rsr_pkg::SQ_STG+1];
  logic [rsr_pkg::SQ_ROOT_W-1:0] root [rsr_pkg::SQ_STG+1];
  logic [rsr_pkg::SQ_REM_W-1:0]  rem  [rsr_pkg::SQ_STG+1];

  assign sum_sq = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rad[0]  <= {1'b0, sum_sq, 8'd0};
      root[0] <= '0;
      rem[0]  <= '0;
    end
  end

  // ---------------- square root, two radicand bits per step ----------------
  for (genvar g = 0; g < rsr_pkg::SQ_STG; g++) begin : g_sqrt
    logic [rsr_pkg::SQ_IN_W-1:0]   rad_c;
    logic [rsr_pkg::SQ_ROOT_W-1:0] root_c;
    logic [rsr_pkg::SQ_REM_W-1:0]  rem_c;

    always_comb begin
      logic [rsr_pkg::SQ_REM_W+1:0] cand;
      logic [rsr_pkg::SQ_REM_W+1:0] trial;
      rad_c  = rad[g];
      root_c = root[g];
      rem_c  = rem[g];
      for (int j = 0; j < rsr_pkg::SQ_PER_STG; j++) begin
        if (g * rsr_pkg::SQ_PER_STG + j < rsr_pkg::SQ_STEPS) begin
          cand  = {rem_c, rad_c[rsr_pkg::SQ_IN_W-1 -: 2]};
          trial = {4'b0000, root_c, 2'b01};
          rad_c = {rad_c[rsr_pkg::SQ_IN_W-3:0], 2'b00};
          if (cand >= trial) begin
            cand   = cand - trial;
            root_c = {root_c[rsr_pkg::SQ_ROOT_W-2:0], 1'b1};
          end else begin
            root_c = {root_c[rsr_pkg::SQ_ROOT_W-2:0], 1'b0};
          end
          rem_c = cand[rsr_pkg::SQ_REM_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_SQ0+g]) begin
        rad[g+1]  <= rad_c;
        root[g+1] <= root_c;
        rem[g+1]  <= rem_c;
      end
    end
  end

  // ---------------- phase: scale * distance ----------------
  logic [rsr_pkg::DIST_W-1:0] radius;
  logic signed [33:0] phase [3];

  assign radius = (root[rsr_pkg::SQ_STG] > {2'b00, rsr_pkg::DIST_MAX})
                ? rsr_pkg::DIST_MAX : root[rsr_pkg::SQ_STG][rsr_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en[ST_P]) begin
      for (int c = 0; c < 3; c++) phase[c] <= scale[c] * $signed({1'b0, radius});
    end
  end

  // ---------------- turns: phase / (2*pi), two partial products ----------------
  logic signed [49:0] pp_lo [3];
  logic signed [49:0] pp_hi [3];

  always_ff @(posedge clk) begin
    if (en[ST_P+1]) begin
      for (int c = 0; c < 3; c++) begin
        pp_lo[c] <= phase[c] * $signed({1'b0, rsr_pkg::INV_LO});
        pp_hi[c] <= phase[c] * $signed({1'b0, rsr_pkg::INV_HI});
      end
    end
  end

  // ---------------- angle and quadrant folding ----------------
  logic signed [FULL_W-1:0] turns [3];
  logic [15:0] angle [3];
  logic [16:0] xq [3];
  logic [2:0]  neg;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      turns[c] = (FULL_W'(pp_hi[c]) <<< 15) + FULL_W'(pp_lo[c]);
      angle[c] = turns[c][ANG_LSB +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_P+2]) begin
      for (int c = 0; c < 3; c++) begin
        xq[c]  <= angle[c][14] ? rsr_pkg::FULL_TURN - {1'b0, angle[c][13:0], 2'b00}
                               : {1'b0, angle[c][13:0], 2'b00};
        neg[c] <= angle[c][15];
      end
    end
  end

  // ---------------- quarter sine polynomial ----------------
  logic [16:0] x2   [3];
  logic [16:0] x_s3 [3];
  logic [2:0]  neg_s3;
  logic [15:0] t1   [3];
  logic [16:0] x2_s4 [3];
  logic [16:0] x_s4 [3];
  logic [2:0]  neg_s4;
  logic [16:0] t2   [3];
  logic [16:0] x_s5 [3];
  logic [2:0]  neg_s5;
  logic [16:0] u    [3];

  logic [33:0] xx  [3];
  logic [28:0] cx2 [3];
  logic [32:0] tx2 [3];
  logic [33:0] tx  [3];
  logic [24:0] lvl [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      xx[c]  = xq[c] * xq[c];
      cx2[c] = rsr_pkg::SIN_C * x2[c];
      tx2[c] = t1[c] * x2_s4[c];
      tx[c]  = t2[c] * x_s5[c];
      lvl[c] = u[c] * rsr_pkg::LEVELS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_P+3]) begin
      for (int c = 0; c < 3; c++) begin
        x2[c]   <= xx[c][32:16];
        x_s3[c] <= xq[c];
      end
      neg_s3 <= neg;
    end
    if (en[ST_P+4]) begin
      for (int c = 0; c < 3; c++) begin
        t1[c]    <= rsr_pkg::SIN_B - {3'b000, cx2[c][28:16]};
        x2_s4[c] <= x2[c];
        x_s4[c]  <= x_s3[c];
      end
      neg_s4 <= neg_s3;
    end
    if (en[ST_P+5]) begin
      for (int c = 0; c < 3; c++) begin
        t2[c]   <= rsr_pkg::SIN_A - tx2[c][32:16];
        x_s5[c] <= x_s4[c];
      end
      neg_s5 <= neg_s4;
    end
    if (en[ST_P+6]) begin
      for (int c = 0; c < 3; c++) begin
        u[c] <= neg_s5[c] ? rsr_pkg::HALF_SCALE - tx[c][32:16]
                          : rsr_pkg::HALF_SCALE + tx[c][32:16];
      end
    end
    // output register: floor(u * 255 / 65536)
    if (en[ST_P+7]) begin
      out_item.red   <= lvl[0][23:16];
      out_item.green <= lvl[1][23:16];
      out_item.blue  <= lvl[2][23:16];
    end
  end

  // ---------------- assertions ----------------
  a_empty_head_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> in_ready) else $error("input stalled with empty head stage");

  a_drain_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |-> in_ready) else $error("taken output did not free pipe");

  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (vld == '0)) else $error("pipe not empty after reset");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_P+2] |-> (xq[0] <= rsr_pkg::FULL_TURN && xq[1] <= rsr_pkg::FULL_TURN
                     && xq[2] <= rsr_pkg::FULL_TURN)) else $error("folded angle out of range");

endmodule

// File: dv/radial_sine_ripple_pixel_chk.sv
`timescale 1ns / 100ps
// ============================================================================
// radial_sine_ripple_pixel_chk
// Watches the pixel and RGB channels and the register write port. Predicts
// each RGB item from a register copy and compares it with what the block
// gives out.
// ============================================================================
module radial_sine_ripple_pixel_chk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rsr_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rsr_pkg::out_item_t             out_item,
  input  logic                           wr_en,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rsr_pkg::CFG_DATA_W-1:0] wr_data,
  output int                             errors,
  output int                             pending
);

  localparam longint SIDE_CAP  = 4096;
  localparam int     PHASE_SHR = 32;   // scale fraction bits + 20

  logic [12:0] side_q;
  logic [13:0] ox_q, oy_q;
  logic [15:0] sc_r, sc_g, sc_b;
  rsr_pkg::out_item_t rgb_q[$];

  assign pending = rgb_q.size();

  // integer square root, bit-pair method
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // one color channel from distance (Q13.4) and scale (Q4.12)
  function automatic logic [7:0] ripple_level(logic [15:0] scale, logic [16:0] radius);
    logic [63:0] prod, x, x2, t, s, u;
    logic [15:0] angle;
    prod  = longint'($signed(scale)) * longint'(radius) * 64'd683565276;
    angle = prod[PHASE_SHR +: 16];
    x     = {angle[13:0], 2'b00};
    if (angle[14]) x = 64'd65536 - x;
    x2 = (x * x) >> 16;
    t  = 64'd21167 - ((64'd2463 * x2) >> 16);
    t  = 64'd51472 - ((t * x2) >> 16);
    s  = (t * x) >> 16;
    u  = angle[15] ? 64'd32768 - s : 64'd32768 + s;
    return 8'((u * 255) >> 16);
  endfunction

  function automatic rsr_pkg::out_item_t predict_rgb(rsr_pkg::in_item_t p);
    longint    side, cx, cy, dx, dy;
    logic [63:0] d;
    rsr_pkg::out_item_t r;
    side = (longint'(side_q) > SIDE_CAP) ? SIDE_CAP : longint'(side_q);
    cx   = (side >> 1) + longint'($signed(ox_q));
    cy   = (side >> 1) + longint'($signed(oy_q));
    dx   = longint'(p.pixel_x) - cx;
    dy   = longint'(p.pixel_y) - cy;
    d    = int_sqrt(64'(dx * dx + dy * dy) << 8);
    if (d > 64'(rsr_pkg::DIST_MAX)) d = 64'(rsr_pkg::DIST_MAX);
    r.red   = ripple_level(sc_r, d[16:0]);
    r.green = ripple_level(sc_g, d[16:0]);
    r.blue  = ripple_level(sc_b, d[16:0]);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      side_q <= 13'd256;
      ox_q   <= '0;
      oy_q   <= '0;
      sc_r   <= 16'd4096;
      sc_g   <= 16'd4096;
      sc_b   <= 16'd4096;
      errors <= 0;
      rgb_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          rsr_pkg::REG_IMG_SIDE:    side_q <= wr_data[12:0];
          rsr_pkg::REG_OFFSET_X:    ox_q   <= wr_data[13:0];
          rsr_pkg::REG_OFFSET_Y:    oy_q   <= wr_data[13:0];
          rsr_pkg::REG_SCALE_RED:   sc_r   <= wr_data;
          rsr_pkg::REG_SCALE_GREEN: sc_g   <= wr_data;
          rsr_pkg::REG_SCALE_BLUE:  sc_b   <= wr_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) rgb_q.push_back(predict_rgb(in_item));
      if (out_valid && out_ready) begin
        if (rgb_q.size() == 0) begin
          $display("%0t: RGB item with none expected: got %h", $time, out_item);
          errors <= errors + 1;
        end else begin
          rsr_pkg::out_item_t e;
          e = rgb_q.pop_front();
          if (e.red !== out_item.red ||
              e.green !== out_item.green || e.blue !== out_item.blue) begin
            if (e.red !== out_item.red)
              $display("%0t: red expected %0d got %0d", $time, e.red, out_item.red);
            if (e.green !== out_item.green)
              $display("%0t: green expected %0d got %0d", $time, e.green, out_item.green);
            if (e.blue !== out_item.blue)
              $display("%0t: blue expected %0d got %0d", $time, e.blue, out_item.blue);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: dv/radial_sine_ripple_pixel_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// radial_sine_ripple_pixel_tb
// Drives pixel coordinates through the ripple generator under a series of
// register settings, with random stalls on both sides, and lets the checker
// compare every RGB item against its own prediction.
// ============================================================================
module radial_sine_ripple_pixel_tb;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake, write or reset
  localparam int LONG_HOLD   = 300;   // one long output stall
  localparam int DRAIN_WAIT  = 24;    // extra wait after the last RGB item is back

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  rsr_pkg::in_item_t              in_item = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rsr_pkg::out_item_t             out_item;
  logic                           wr_en = 1'b0;
  logic [rsr_pkg::CFG_IDX_W-1:0]  wr_index = '0;
  logic [rsr_pkg::CFG_DATA_W-1:0] wr_data = '0;
  int                             errors, pending;

  // shared knobs: quiet turns idling off on both sides, hold_req asks for
  // the one long output stall
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  radial_sine_ripple_pixel DUT (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
    .out_item, .wr_en, .wr_index, .wr_data
  );

  radial_sine_ripple_pixel_chk chk (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
    .out_item, .wr_en, .wr_index, .wr_data, .errors, .pending
  );

  // watchdog: any handshake, write or reset resets the count
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en || rst)
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("radial_sine_ripple_pixel_tb failed");
        $finish;
      end
    end
  end

  // output side: random stall bursts, one long hold, none when quiet
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet || $urandom_range(0, 4) != 0) begin
        out_ready <= 1'b1;
      end else begin
        n = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // offer one pixel item and wait for its handshake; ready is looked at on
  // the falling edge so the decision never races the block's own updates
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
    logic hit;
    in_valid <= 1'b1;
    in_item  <= '{pixel_x: px, pixel_y: py};
    do begin
      @(negedge clk);
      hit = in_ready;
      @(posedge clk);
    end while (!hit);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every RGB item to come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // full register set, plus a write to an unused index that must be ignored
  task automatic set_pattern(input int side, input int ox, input int oy,
                             input int sr, input int sg, input int sb);
    write_reg(rsr_pkg::REG_IMG_SIDE, 16'(side));
    write_reg(rsr_pkg::REG_OFFSET_X, 16'(ox));
    write_reg(rsr_pkg::REG_OFFSET_Y, 16'(oy));
    write_reg(rsr_pkg::REG_SCALE_RED, 16'(sr));
    write_reg(rsr_pkg::REG_SCALE_GREEN, 16'(sg));
    write_reg(rsr_pkg::REG_SCALE_BLUE, 16'(sb));
    write_reg(rsr_pkg::CFG_IDX_W'(6 + $urandom_range(0, 1)), 16'($urandom));
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // random pixels: mostly anywhere, some near the default ripple center
  task automatic random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_pixel(12'($urandom_range(0, 40) + 108), 12'($urandom_range(0, 40) + 108));
      else
        send_pixel(12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults from reset: corners, center, near center
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd128, 12'd128);
    send_pixel(12'd129, 12'd128);
    send_pixel(12'd128, 12'd131);
    send_pixel(12'd2048, 12'd1000);
    drain();

    // side zero, extreme scales of both signs and zero
    set_pattern(0, 0, 0, 32767, -32768, 0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd7, 12'd3);
    drain();

    // side above the cap, far center so the distance saturates
    set_pattern(8191, 4096, 4096, 1, -1, 4096);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd0);
    drain();

    // cap exactly, center pulled to the far negative corner
    set_pattern(4096, -4096, -4096, -4096, 12345, -20000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd1, 12'd1);
    drain();

    // random phases; every third one runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph % 3 == 2);
      set_pattern($urandom_range(0, 8191), int'($urandom_range(0, 8192)) - 4096,
                  int'($urandom_range(0, 8192)) - 4096,
                  int'($urandom), int'($urandom), int'($urandom));
      if (ph == 3) hold_req = 1'b1;   // long output stall fills the pipe
      random_pixels(200);
      drain();
    end

    // last part: defaults back, no idling anywhere
    quiet = 1'b1;
    set_pattern(256, 0, 0, 4096, 4096, 4096);
    random_pixels(100);
    drain();

    if (errors == 0)
      $display("radial_sine_ripple_pixel_tb passed");
    else
      $display("radial_sine_ripple_pixel_tb failed");
    $finish;
  end

endmodule
